### rtl/size_class_block_pool_top_defines.svh
// Assertion macros for the size-class block pool.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef SIZE_CLASS_BLOCK_POOL_TOP_DEFINES_SVH
`define SIZE_CLASS_BLOCK_POOL_TOP_DEFINES_SVH

// implication checked on every clock, off during reset
`define SCBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// antecedent now, consequent in the next cycle
`define SCBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/scbp_pkg.sv
// Shared types and constants of the size-class block pool.
// No dependencies; used by the interfaces, the stack RAM and the top level.
`default_nettype none

package scbp_pkg;

  localparam int unsigned LEN_W      = 32;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned CLSF_W     = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned MAXF_W     = 9;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BASE   = 3'd4;
  localparam int unsigned          NUM_CFG_CLS    = 4;

  localparam logic [MAXF_W-1:0] CLASS_MAX_RST = 9'd256;

  typedef enum logic {
    REQ_ALLOC   = 1'b0,
    REQ_RELEASE = 1'b1
  } req_type_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANT   = 2'd0,
    ST_REFUSE  = 2'd1,
    ST_RELEASE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CHECK,
    S_GROW,
    S_READ
  } state_e;

  typedef struct packed {
    logic we;
    logic re;
  } ram_ctl_t;

  // block size after reset: 16 KiB times 4^k
  function automatic logic [LEN_W-1:0] class_bytes_rst(int unsigned k);
    return 32'd16384 << (2 * k);
  endfunction

endpackage

`default_nettype wire

### rtl/scbp_if.sv
// Request and response channels of the size-class block pool.
// Depends on scbp_pkg for field widths.
`default_nettype none

interface scbp_req_if import scbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [LEN_W-1:0]  request_length;
  logic [CLSF_W-1:0] release_class;
  logic [IDX_W-1:0]  release_index;

  modport source (output valid, req_type, request_length, release_class, release_index,
                  input ready);
  modport sink (input valid, req_type, request_length, release_class, release_index,
                output ready);
endinterface

interface scbp_rsp_if import scbp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CLSF_W-1:0]   granted_class;
  logic [IDX_W-1:0]    granted_index;
  logic [LEN_W-1:0]    granted_length;

  modport source (output valid, status, granted_class, granted_index, granted_length,
                  input ready);
  modport sink (input valid, status, granted_class, granted_index, granted_length,
                output ready);
endinterface

`default_nettype wire

### rtl/scbp_stack_ram.sv
// Free-stack storage: single-port synchronous RAM with a registered read.
// Depends on scbp_pkg for the entry width and the control struct.
`default_nettype none

module scbp_stack_ram import scbp_pkg::*; #(
  parameter int unsigned ADDR_W = 10,
  parameter int unsigned DEPTH  = 1024
) (
  input  wire logic              clk_i,
  input  wire ram_ctl_t          ctl_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire logic [IDX_W-1:0]  wdata_i,
  output logic      [IDX_W-1:0]  rdata_o
);

  logic [IDX_W-1:0] mem_q [DEPTH];
  logic [IDX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/size_class_block_pool_top.sv
// Size-class block pool: LIFO free stacks per class, grown on demand.
// A release or a refusal by size ends in the decode state, a refusal at the
// last class in the check state; a grant from a non-empty stack passes the
// check and read states, checking again for each class passed over. A growth
// pushes each fresh index (each push is one write of the stack RAM), then
// checks the stack again. While the result register still holds an earlier
// result, the item waits until it is taken. Items are handled one at a time;
// the result register lets the next item in while a result waits.
// Depends on scbp_pkg, scbp_if, scbp_stack_ram and the defines header.
`default_nettype none
`include "size_class_block_pool_top_defines.svh"

module size_class_block_pool_top import scbp_pkg::*; #(
  parameter int unsigned NUM_CLASSES   = 4,
  parameter int unsigned MAX_BLOCKS    = 256,
  parameter int unsigned INIT_BLOCKS   = 16,
  parameter int unsigned GROWTH_BLOCKS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  scbp_req_if.sink                   req_i,
  scbp_rsp_if.source                 rsp_o
);

  localparam int unsigned CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned SLOT_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned ADDR_W = CLS_W + SLOT_W;
  localparam int unsigned DEPTH  = NUM_CLASSES * (2 ** SLOT_W);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCKS);

  state_e state_q, state_d;

  logic [LEN_W-1:0]  bytes_q [NUM_CLASSES];
  logic [MAXF_W-1:0] max_q   [NUM_CLASSES];
  logic [CNT_W-1:0]  cnt_q   [NUM_CLASSES];
  logic [CNT_W-1:0]  made_q  [NUM_CLASSES];

  logic              type_q;
  logic [LEN_W-1:0]  len_q;
  logic [CLSF_W-1:0] rcls_q;
  logic [IDX_W-1:0]  ridx_q;

  logic [CLS_W-1:0]  k_q;
  logic [CNT_W-1:0]  gi_q;
  logic [CNT_W-1:0]  n_q;

  logic              out_valid_q;
  status_e           status_q;
  logic [CLSF_W-1:0] gcls_q;
  logic [IDX_W-1:0]  gidx_q;
  logic [LEN_W-1:0]  glen_q;

  logic              out_free;
  logic              fit_any;
  logic [CLS_W-1:0]  fit_k;
  logic [CLS_W-1:0]  rcls_idx;
  logic              rel_ok;
  logic [CNT_W-1:0]  cur_cnt;
  logic [CNT_W-1:0]  cur_made;
  logic [CNT_W-1:0]  cur_dec;
  logic [CNT_W-1:0]  lim;
  logic [CNT_W-1:0]  grow_n;
  logic              can_grow;
  logic              last_cls;
  logic              grow_last;

  ram_ctl_t          ram_ctl;
  logic [ADDR_W-1:0] ram_addr;
  logic [IDX_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]  ram_rdata;
  logic              out_load;
  status_e           out_status;

  assign out_free  = !out_valid_q || rsp_o.ready;
  assign rcls_idx  = CLS_W'(rcls_q);
  assign rel_ok    = (32'(rcls_q) < NUM_CLASSES) && (cnt_q[rcls_idx] < MAX_CNT);
  assign cur_cnt   = cnt_q[k_q];
  assign cur_made  = made_q[k_q];
  assign cur_dec   = cur_cnt - 1'b1;
  assign last_cls  = (32'(k_q) == NUM_CLASSES - 1);
  assign grow_last = (gi_q == n_q - 1'b1);

  // first class large enough for the request
  always_comb begin
    fit_any = 1'b0;
    fit_k   = '0;
    for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
      if (len_q <= bytes_q[k]) begin
        fit_any = 1'b1;
        fit_k   = CLS_W'(k);
      end
    end
  end

  // growth size of the current class
  always_comb begin
    if (32'(k_q) >= NUM_CFG_CLS) begin
      lim = MAX_CNT;
    end else if (32'(max_q[k_q]) > MAX_BLOCKS) begin
      lim = MAX_CNT;
    end else begin
      lim = CNT_W'(max_q[k_q]);
    end
    if (cur_made == '0) begin
      grow_n   = (INIT_BLOCKS < 32'(lim)) ? CNT_W'(INIT_BLOCKS) : lim;
      can_grow = (grow_n != '0);
    end else begin
      grow_n   = (32'(lim - cur_made) > GROWTH_BLOCKS) ? CNT_W'(GROWTH_BLOCKS)
                                                       : lim - cur_made;
      can_grow = (lim > cur_made);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (type_q == REQ_RELEASE || !fit_any) begin
          if (out_free) state_d = S_IDLE;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (cur_cnt != '0) begin
          state_d = S_READ;
        end else if (can_grow) begin
          state_d = S_GROW;
        end else if (last_cls && out_free) begin
          state_d = S_IDLE;
        end
      end
      S_GROW: begin
        if (grow_last) state_d = S_CHECK;
      end
      S_READ: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ram_ctl    = '0;
    ram_addr   = {k_q, cur_cnt[SLOT_W-1:0]};
    ram_wdata  = ridx_q;
    out_load   = 1'b0;
    out_status = ST_REFUSE;
    case (state_q)
      S_DECODE: begin
        if (type_q == REQ_RELEASE) begin
          ram_ctl.we = out_free && rel_ok;
          ram_addr   = {rcls_idx, cnt_q[rcls_idx][SLOT_W-1:0]};
          out_load   = out_free;
          out_status = ST_RELEASE;
        end else if (!fit_any) begin
          out_load = out_free;
        end
      end
      S_CHECK: begin
        if (cur_cnt != '0) begin
          ram_ctl.re = 1'b1;
          ram_addr   = {k_q, cur_dec[SLOT_W-1:0]};
        end else if (!can_grow && last_cls) begin
          out_load = out_free;
        end
      end
      S_GROW: begin
        ram_ctl.we = (cur_cnt < MAX_CNT);
        ram_wdata  = IDX_W'(cur_made + gi_q);
      end
      S_READ: begin
        out_load   = out_free;
        out_status = ST_GRANT;
      end
      default: ;
    endcase
  end

  scbp_stack_ram #(
    .ADDR_W (ADDR_W),
    .DEPTH  (DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .ctl_i   (ram_ctl),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      gi_q        <= '0;
      n_q         <= '0;
      for (int k = 0; k < NUM_CLASSES; k++) begin
        bytes_q[k] <= class_bytes_rst(k);
        max_q[k]   <= CLASS_MAX_RST;
        cnt_q[k]   <= '0;
        made_q[k]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i < CFG_MAX_BASE) begin
          if (32'(cfg_idx_i - CFG_BYTES_BASE) < NUM_CLASSES) begin
            bytes_q[CLS_W'(cfg_idx_i - CFG_BYTES_BASE)] <= cfg_data_i;
          end
        end else if (32'(cfg_idx_i - CFG_MAX_BASE) < NUM_CLASSES) begin
          max_q[CLS_W'(cfg_idx_i - CFG_MAX_BASE)] <= cfg_data_i[MAXF_W-1:0];
        end
      end
      case (state_q)
        S_DECODE: begin
          if (type_q == REQ_RELEASE) begin
            if (out_free && rel_ok) cnt_q[rcls_idx] <= cnt_q[rcls_idx] + 1'b1;
          end else begin
            k_q <= fit_k;
          end
        end
        S_CHECK: begin
          if (cur_cnt != '0) begin
            cnt_q[k_q] <= cur_dec;
          end else if (can_grow) begin
            n_q  <= grow_n;
            gi_q <= '0;
          end else if (!last_cls) begin
            k_q <= k_q + 1'b1;
          end
        end
        S_GROW: begin
          if (cur_cnt < MAX_CNT) cnt_q[k_q] <= cur_cnt + 1'b1;
          gi_q <= gi_q + 1'b1;
          if (grow_last) made_q[k_q] <= cur_made + n_q;
        end
        default: ;
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_i.valid) begin
      type_q <= req_i.req_type;
      len_q  <= req_i.request_length;
      rcls_q <= req_i.release_class;
      ridx_q <= req_i.release_index;
    end
    if (out_load) begin
      status_q <= out_status;
      if (out_status == ST_GRANT) begin
        gcls_q <= CLSF_W'(k_q);
        gidx_q <= ram_rdata;
        glen_q <= len_q;
      end else begin
        gcls_q <= '0;
        gidx_q <= '0;
        glen_q <= '0;
      end
    end
  end

  assign req_i.ready          = (state_q == S_IDLE);
  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = status_q;
  assign rsp_o.granted_class  = gcls_q;
  assign rsp_o.granted_index  = gidx_q;
  assign rsp_o.granted_length = glen_q;

  `SCBP_ASSERT(a_rsp_from_work, $rose(rsp_o.valid) |-> $past(state_q) != S_IDLE, "result without item")
  `SCBP_ASSERT(a_grow_in_range, state_q == S_GROW |-> gi_q < n_q, "growth counter overrun")
  `SCBP_ASSERT(a_count_bound, state_q == S_CHECK |-> cur_cnt <= MAX_CNT, "stack count overflow")
  `SCBP_ASSERT_NEXT(a_grow_ends, state_q == S_GROW && grow_last, state_q == S_CHECK, "growth did not end")

endmodule

`default_nettype wire
